// File: sv/bfd_pkg.sv
// Shared types and constants for the bounded FIFO with drop policies.
// No dependencies; imported by every other file of the block.
package bfd_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 7;
    localparam int SEED_W = 16;
    localparam int OCC_W  = 7;
    localparam int DIV_CNT_W = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;
    localparam logic [SEED_W-1:0] LFSR_POLY  = 16'hB400;
    // Quarter of the queue is dropped: ceil(n/4) = (n + 3) >> 2
    localparam int DROP_SHIFT = 2;

    typedef enum logic [0:0] {
        CFG_CAPACITY,
        CFG_SEED
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ,
        CMD_ENQ_DROP_OLD,
        CMD_ENQ_DROP_RND,
        CMD_DEQ
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS,
        KIND_DEQ,
        KIND_DROP
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [1:0] {
        OUT_DROP,
        OUT_FIN_DATA,
        OUT_FIN_STATUS
    } t_out_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIN,
        S_DEQ_OUT,
        S_OLD_OUT,
        S_PUSH,
        S_DRAW,
        S_DIV,
        S_PRD,
        S_PWR,
        S_EMIT,
        S_EMIT_OUT,
        S_COMP,
        S_COMP_WR
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     rd_oldest;
        logic     pop;
        logic     push;
        logic     lfsr_step;
        logic     div_step;
        logic     perm_rd;
        logic     perm_wr;
        logic     emit_rd;
        logic     i_inc;
        logic     comp_init;
        logic     comp_rd;
        logic     comp_wr;
        logic     comp_done;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic count_zero;
        logic div_last;
        logic k_last;
        logic i_done;
        logic mark_cur;
        logic keep_cur;
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/bfd_ctrl.sv
// Controller state machine for the bounded FIFO with drop policies.
// Depends on bfd_pkg; drives bfd_dpath through t_dp_cmd, reads t_dp_stat.
module bfd_ctrl import bfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_DEQ: begin
                        if (i_stat.count_zero) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.rd_oldest = 1'b1;
                            n_state         = S_DEQ_OUT;
                        end
                    end
                    CMD_ENQ_DROP_OLD: begin
                        if (i_stat.count_zero) begin
                            n_state = S_PUSH;
                        end else begin
                            o_cmd.rd_oldest = 1'b1;
                            n_state         = S_OLD_OUT;
                        end
                    end
                    CMD_ENQ_DROP_RND: begin
                        n_state = i_stat.count_zero ? S_PUSH : S_DRAW;
                    end
                    default: n_state = S_PUSH;
                endcase
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_FIN_STATUS;
                    n_state        = S_IDLE;
                end
            end
            S_DEQ_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_FIN_DATA;
                    o_cmd.pop      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_OLD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DROP;
                    o_cmd.pop      = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_FIN_STATUS;
                    n_state        = S_IDLE;
                end
            end
            S_DRAW: begin
                o_cmd.lfsr_step = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                o_cmd.perm_rd = 1'b1;
                n_state       = S_PWR;
            end
            S_PWR: begin
                o_cmd.perm_wr = 1'b1;
                n_state       = i_stat.k_last ? S_EMIT : S_DRAW;
            end
            S_EMIT: begin
                if (i_stat.i_done) begin
                    o_cmd.comp_init = 1'b1;
                    n_state         = S_COMP;
                end else if (i_stat.mark_cur) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT_OUT;
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_EMIT_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DROP;
                    o_cmd.i_inc    = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_COMP: begin
                if (i_stat.i_done) begin
                    o_cmd.comp_done = 1'b1;
                    n_state         = S_PUSH;
                end else if (i_stat.keep_cur) begin
                    o_cmd.comp_rd = 1'b1;
                    n_state       = S_COMP_WR;
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_COMP_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = S_COMP;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/bfd_dpath.sv
// Datapath: entry store, permutation store, remove marks, LFSR, remainder unit,
// counters and output register. Depends on bfd_pkg; steered by bfd_ctrl.
module bfd_dpath import bfd_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [CMD_W-1:0]       i_in_cmd,
    input  logic [ENTRY_WIDTH-1:0] i_in_payload,
    input  logic                   i_cfg_valid,
    input  logic [0:0]             i_cfg_index,
    input  logic [SEED_W-1:0]      i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [KIND_W-1:0]      o_out_kind,
    output logic [ENTRY_WIDTH-1:0] o_out_entry,
    output logic [STAT_W-1:0]      o_out_status,
    output logic [OCC_W-1:0]       o_out_occ,
    output logic                   o_out_full,
    output logic                   o_out_empty,
    output logic                   o_out_last
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + CAP_W;

    logic [ENTRY_WIDTH-1:0] store_mem [DEPTH];
    logic [AW-1:0]          perm_mem  [DEPTH];

    logic [CAP_W-1:0]       r_cap;
    logic [SEED_W-1:0]      r_lfsr;
    logic [AW-1:0]          r_op;
    logic [CW-1:0]          r_count;
    t_cmd                   r_cmd;
    logic [ENTRY_WIDTH-1:0] r_pay;
    logic [CW-1:0]          r_occ_fin;
    logic                   r_push_ok;
    t_status                r_stat_fin;
    logic [CW-1:0]          r_d;
    logic [CW-1:0]          r_k;
    logic [CW-1:0]          r_i;
    logic [CW-1:0]          r_j;
    logic [SEED_W-1:0]      r_div_val;
    logic [CW-1:0]          r_rem;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [DEPTH-1:0]       r_mark;
    logic [DEPTH-1:0]       r_pv;
    logic [AW-1:0]          r_pa_data, r_pb_data, r_pa_addr, r_pb_addr;
    logic                   r_pa_v, r_pb_v;
    logic [ENTRY_WIDTH-1:0] r_rdata;
    logic                   r_ov;
    t_kind                  r_okind;
    logic [ENTRY_WIDTH-1:0] r_oentry;
    t_status                r_ostat;
    logic [CW-1:0]          r_oocc;
    logic                   r_ofull, r_oempty, r_olast;

    logic [CW-1:0]          w_effcap;
    logic [CMPW-1:0]        w_cap_ext;
    logic [CW-1:0]          w_m;
    logic [CW-1:0]          w_d;
    logic                   w_push_ok;
    logic [SEED_W-1:0]      w_lfsr_nxt;
    logic [CW-1:0]          w_range;
    logic [CW:0]            w_div_t;
    logic [CW-1:0]          w_rem_nxt;
    logic [AW-1:0]          w_va, w_vb;
    logic [CW-1:0]          w_rev_i;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [ENTRY_WIDTH-1:0] w_wr_data;
    t_cmd                   w_in_cmd;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] op,
                                             input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(op) + (CW+1)'(x);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return AW'(s);
    endfunction

    assign w_in_cmd  = t_cmd'(i_in_cmd);
    assign w_cap_ext = CMPW'(r_cap);
    assign w_effcap  = (r_cap == '0) ? CW'(1) :
                       (w_cap_ext > CMPW'(DEPTH)) ? CW'(DEPTH) : CW'(w_cap_ext);
    assign w_d       = CW'(((CW+2)'(r_count) + (CW+2)'(3)) >> DROP_SHIFT);

    // Count left once the removals of this command are done
    always_comb begin
        case (w_in_cmd)
            CMD_ENQ:          w_m = r_count;
            CMD_ENQ_DROP_RND: w_m = r_count - w_d;
            default:          w_m = (r_count == '0) ? r_count : r_count - CW'(1);
        endcase
    end
    assign w_push_ok = (w_m < w_effcap);

    assign w_lfsr_nxt = {1'b0, r_lfsr[SEED_W-1:1]} ^ (r_lfsr[0] ? LFSR_POLY : '0);
    assign w_range    = r_count - r_k;
    assign w_div_t    = {r_rem, r_div_val[SEED_W-1]};
    assign w_rem_nxt  = (w_div_t >= {1'b0, w_range}) ? CW'(w_div_t - {1'b0, w_range})
                                                     : CW'(w_div_t);
    // Unwritten permutation slots read as their own index
    assign w_va    = r_pa_v ? r_pa_data : r_pa_addr;
    assign w_vb    = r_pb_v ? r_pb_data : r_pb_addr;
    assign w_rev_i = r_count - CW'(1) - r_i;

    always_comb begin
        w_rd_en   = i_cmd.rd_oldest | i_cmd.emit_rd | i_cmd.comp_rd;
        w_rd_addr = r_op;
        if (i_cmd.emit_rd) begin
            w_rd_addr = f_slot(r_op, w_rev_i);
        end else if (i_cmd.comp_rd) begin
            w_rd_addr = f_slot(r_op, r_i);
        end
        w_wr_en   = (i_cmd.push & r_push_ok) | i_cmd.comp_wr;
        w_wr_addr = i_cmd.comp_wr ? f_slot(r_op, r_j) : f_slot(r_op, r_count);
        w_wr_data = i_cmd.comp_wr ? r_rdata : r_pay;
    end

    // Survivors are packed toward the oldest slot; reads stay ahead of writes
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            store_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= store_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.perm_wr) begin
            perm_mem[r_pa_addr] <= w_vb;
        end
        if (i_cmd.perm_rd) begin
            r_pa_data <= perm_mem[r_rem[AW-1:0]];
            r_pb_data <= perm_mem[AW'(w_range - CW'(1))];
            r_pa_addr <= r_rem[AW-1:0];
            r_pb_addr <= AW'(w_range - CW'(1));
            r_pa_v    <= r_pv[r_rem[AW-1:0]];
            r_pb_v    <= r_pv[AW'(w_range - CW'(1))];
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= w_in_cmd;
            r_pay      <= i_in_payload;
            r_push_ok  <= w_push_ok;
            r_occ_fin  <= (w_in_cmd == CMD_DEQ) ? w_m : w_m + CW'(w_push_ok);
            r_d        <= w_d;
            r_k        <= '0;
            r_i        <= '0;
            if (w_in_cmd == CMD_DEQ) begin
                r_stat_fin <= (r_count == '0) ? ST_EMPTY : ST_OK;
            end else begin
                r_stat_fin <= w_push_ok ? ST_OK : ST_FULL;
            end
        end
        if (i_cmd.lfsr_step) begin
            r_div_val <= w_lfsr_nxt;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_val <= r_div_val << 1;
            r_rem     <= w_rem_nxt;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.perm_wr) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.comp_init) begin
            r_i <= '0;
            r_j <= '0;
        end
        if (i_cmd.i_inc || i_cmd.comp_wr) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.comp_wr) begin
            r_j <= r_j + CW'(1);
        end
        if (i_cmd.out_load) begin
            r_oocc   <= r_occ_fin;
            r_ofull  <= (r_occ_fin >= w_effcap);
            r_oempty <= (r_occ_fin == '0);
            case (i_cmd.out_sel)
                OUT_DROP: begin
                    r_okind  <= KIND_DROP;
                    r_oentry <= r_rdata;
                    r_ostat  <= ST_OK;
                    r_olast  <= 1'b0;
                end
                OUT_FIN_DATA: begin
                    r_okind  <= KIND_DEQ;
                    r_oentry <= r_rdata;
                    r_ostat  <= r_stat_fin;
                    r_olast  <= 1'b1;
                end
                default: begin
                    r_okind  <= KIND_STATUS;
                    r_oentry <= '0;
                    r_ostat  <= r_stat_fin;
                    r_olast  <= 1'b1;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_lfsr  <= SEED_RESET;
            r_op    <= '0;
            r_count <= '0;
            r_mark  <= '0;
            r_pv    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_pv <= '0;
            end
            if (i_cmd.pop) begin
                r_op    <= f_slot(r_op, CW'(1));
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.push && r_push_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.lfsr_step) begin
                r_lfsr <= w_lfsr_nxt;
            end
            if (i_cmd.perm_wr) begin
                r_mark[w_va]    <= 1'b1;
                r_pv[r_pa_addr] <= 1'b1;
            end
            if (i_cmd.comp_done) begin
                r_count <= r_j;
                r_mark  <= '0;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CAPACITY: r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_SEED:     r_lfsr <= (i_cfg_data == '0) ? SEED_RESET : i_cfg_data;
                    default:      r_cap  <= r_cap;
                endcase
            end
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.count_zero = (r_count == '0);
        o_stat.div_last   = (r_div_cnt == {DIV_CNT_W{1'b1}});
        o_stat.k_last     = (r_k + CW'(1) == r_d);
        o_stat.i_done     = (r_i == r_count);
        o_stat.mark_cur   = r_mark[r_i[AW-1:0]];
        o_stat.keep_cur   = ~r_mark[w_rev_i[AW-1:0]];
        o_stat.out_free   = ~r_ov | i_out_ready;
    end

    assign o_out_valid  = r_ov;
    assign o_out_kind   = r_okind;
    assign o_out_entry  = r_oentry;
    assign o_out_status = r_ostat;
    assign o_out_occ    = OCC_W'(r_oocc);
    assign o_out_full   = r_ofull;
    assign o_out_empty  = r_oempty;
    assign o_out_last   = r_olast;

endmodule

// File: sv/bounded_fifo_with_drop_policies_core.sv
// Channel  Handshake                    Payload
// s_axis   i_s_axis_tvalid/o_..._tready tuser=command, tdata=payload
// m_axis   o_m_axis_tvalid/i_..._tready tuser=kind, tdata=entry..is_empty, tlast=last
// cfg      i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Enqueue and dequeue go via decode to a result state; drop-oldest emits the oldest first.
// Random drop: ceil(n/4) draws, each an LFSR step, a 16-step remainder pass and a permutation
// update; then a scan that emits each marked entry as a drop, then a compaction pass that
// packs the kept entries, through the entry store. One item is in work at a time.
// Reset is synchronous, active low; the entry store needs no clearing pass.
// A stalled result holds the sequencer only when a new result must be loaded.
// Top level; depends on bfd_pkg, bfd_ctrl and bfd_dpath.
module bounded_fifo_with_drop_policies_core import bfd_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
    localparam int IN_DW  = ((ENTRY_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((ENTRY_WIDTH + STAT_W + OCC_W + 2 + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [IN_DW-1:0]    i_s_axis_tdata,   // payload
    input  logic [CMD_W-1:0]    i_s_axis_tuser,   // command
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OUT_DW-1:0]   o_m_axis_tdata,   // entry, status, occupancy, is_full, is_empty
    output logic [KIND_W-1:0]   o_m_axis_tuser,   // kind
    output logic                o_m_axis_tlast,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [SEED_W-1:0]   i_cfg_data
);

    localparam int PACK_W = ENTRY_WIDTH + STAT_W + OCC_W + 2;

    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic [ENTRY_WIDTH-1:0] w_entry;
    logic [STAT_W-1:0]      w_status;
    logic [OCC_W-1:0]       w_occ;
    logic                   w_full, w_empty;

    bfd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    bfd_dpath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_cmd     (i_s_axis_tuser),
        .i_in_payload (i_s_axis_tdata[ENTRY_WIDTH-1:0]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_kind   (o_m_axis_tuser),
        .o_out_entry  (w_entry),
        .o_out_status (w_status),
        .o_out_occ    (w_occ),
        .o_out_full   (w_full),
        .o_out_empty  (w_empty),
        .o_out_last   (o_m_axis_tlast)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_DW'({w_empty, w_full, w_occ, w_status, w_entry});

    a_drop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_DROP) |-> !o_m_axis_tlast)
        else $error("dropped word flagged as last");

    a_deq_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_DEQ)
            |-> (o_m_axis_tlast && o_m_axis_tdata[ENTRY_WIDTH+STAT_W-1:ENTRY_WIDTH] == ST_OK))
        else $error("dequeued word without ok status or last");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second word accepted while one is in work");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[PACK_W-1] == (w_occ == '0)))
        else $error("is_empty disagrees with occupancy");

endmodule
